### sv/risk_grid_hysteresis_cost_defines.svh
// Assertion macros shared by the risk grid cost block.
`ifndef RISK_GRID_HYSTERESIS_COST_DEFINES_SVH
`define RISK_GRID_HYSTERESIS_COST_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define RHC_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rhc assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define RHC_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rhc assertion failed");

`endif

### sv/rhc_pkg.sv
package rhc_pkg;

   // Grid geometry.
   localparam int GRID_CELLS = 1024;
   localparam int GRID_SIDE  = 32;
   localparam int ADDR_W     = $clog2(GRID_CELLS);
   localparam int SIDE_W     = $clog2(GRID_SIDE);
   localparam int SPAN_W     = SIDE_W + 1;
   localparam int CELLS_W    = $clog2(GRID_CELLS + 1);

   // Field widths.
   localparam int INDEX_W = 10;
   localparam int PROB_W  = 17;
   localparam int LEVEL_W = 16;
   localparam int COST_W  = 7;
   localparam int RANGE_W = 12;
   localparam int TOTAL_W = 11;

   // Configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // Fixed-point limits.
   localparam int Q_ONE     = 65536;
   localparam int ACT_MIN   = 655;
   localparam int ACT_MAX   = 64880;
   localparam int COST_MAX  = 80;
   localparam int RANGE_MAX = 2048;
   localparam int COUNT_MAX = 2047;

   // Range test: centre offsets are a half-cell count times 64, so squares carry a shift of 12.
   localparam int SQ_W        = 2 * SIDE_W;
   localparam int DIST_W      = 2 * RANGE_W;
   localparam int POS_SQ_SHIFT = 12;

   // Cost divider.
   localparam int QUOT_W = COST_W;
   localparam int STEP_W = $clog2(QUOT_W);
   localparam int PROD_W = PROB_W + COST_W;
   localparam int NUM_W  = PROD_W + 1;

   // Work queue between front and back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ENABLE  = 3'd0,
      CSR_SHADOW  = 3'd1,
      CSR_ACTIVATE = 3'd2,
      CSR_RELEASE = 3'd3,
      CSR_CEILING = 3'd4,
      CSR_RANGE   = 3'd5
   } csr_index_type;

   // Operation carried by one request word.
   typedef enum logic {
      OP_CELL  = 1'b0,
      OP_CLEAR = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      KIND_CLEAR,
      KIND_OFF,
      KIND_CELL
   } kind_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_SQUARE,
      F_PUSH
   } front_state_type;

   typedef enum logic [3:0] {
      B_INIT,
      B_IDLE,
      B_READ,
      B_LEVEL,
      B_MUL,
      B_PREP,
      B_DIV,
      B_FIN,
      B_WIPE
   } back_state_type;

   // Configuration as used, already clamped.
   typedef struct packed {
      logic               enabled;
      logic               shadow;
      logic [LEVEL_W-1:0] act_level;
      logic [LEVEL_W-1:0] rel_level;
      logic [COST_W-1:0]  ceiling;
      logic [RANGE_W-1:0] range;
   } cfg_type;

   // One classified word handed from front to back.
   typedef struct packed {
      kind_type           kind;
      logic [INDEX_W-1:0] index;
      logic [PROB_W-1:0]  prob;
      logic               in_grid;
      logic               eligible;
      logic               last;
   } work_type;

endpackage

### sv/rhc_front.sv
module rhc_front (
   input  logic                       clock,
   input  logic                       reset,
   input  rhc_pkg::cfg_type           cfg,
   input  logic                       init_busy,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_op,
   input  logic [rhc_pkg::INDEX_W-1:0] req_cell_index,
   input  logic [rhc_pkg::PROB_W-1:0] req_probability,
   input  logic                       req_visible,
   input  logic                       req_frame_last,
   output logic                       push_valid,
   input  logic                       push_ready,
   output rhc_pkg::work_type          push_data
);

   rhc_pkg::front_state_type state_ff, state_in;

   logic                        op_ff;
   logic [rhc_pkg::INDEX_W-1:0] index_ff;
   logic [rhc_pkg::PROB_W-1:0]  prob_ff;
   logic                        visible_ff;
   logic                        last_ff;

   logic [rhc_pkg::SQ_W-1:0]   sqx_ff, sqx_in;
   logic [rhc_pkg::SQ_W-1:0]   sqy_ff, sqy_in;
   logic [rhc_pkg::DIST_W-1:0] rsq_ff, rsq_in;

   logic [rhc_pkg::SIDE_W-1:0] mag_x, mag_y;
   logic [rhc_pkg::DIST_W-1:0] dist_sq;
   logic                       near;
   logic                       in_grid;

   // Distance from the grid centre, in half cells, of a row or column centre.
   function automatic logic [rhc_pkg::SIDE_W-1:0] centre_mag(
      input logic [rhc_pkg::SIDE_W-1:0] pos
   );
      logic [rhc_pkg::SPAN_W-1:0] twice;
      logic [rhc_pkg::SPAN_W-1:0] side;
      twice = {pos, 1'b1};
      side  = rhc_pkg::SPAN_W'(rhc_pkg::GRID_SIDE);
      if (twice >= side) begin
         return rhc_pkg::SIDE_W'(twice - side);
      end else begin
         return rhc_pkg::SIDE_W'(side - twice);
      end
   endfunction

   // Sequencer: take a word, square the offsets, then hand it on.
   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      push_valid = 1'b0;
      unique case (state_ff)
         rhc_pkg::F_IDLE: begin
            req_ready = !init_busy;
            if (req_valid && !init_busy) begin
               state_in = rhc_pkg::F_SQUARE;
            end
         end
         rhc_pkg::F_SQUARE: begin
            state_in = rhc_pkg::F_PUSH;
         end
         rhc_pkg::F_PUSH: begin
            push_valid = 1'b1;
            if (push_ready) begin
               state_in = rhc_pkg::F_IDLE;
            end
         end
         default: begin
            state_in = rhc_pkg::F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rhc_pkg::F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Capture the accepted word.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         op_ff      <= req_op;
         index_ff   <= req_cell_index;
         prob_ff    <= req_probability;
         visible_ff <= req_visible;
         last_ff    <= req_frame_last;
      end
   end

   // Squares of the centre offsets and of the minimum range.
   assign mag_x  = centre_mag(index_ff[rhc_pkg::SIDE_W-1:0]);
   assign mag_y  = centre_mag(index_ff[rhc_pkg::SIDE_W +: rhc_pkg::SIDE_W]);
   assign sqx_in = rhc_pkg::SQ_W'(mag_x) * rhc_pkg::SQ_W'(mag_x);
   assign sqy_in = rhc_pkg::SQ_W'(mag_y) * rhc_pkg::SQ_W'(mag_y);
   assign rsq_in = rhc_pkg::DIST_W'(cfg.range) * rhc_pkg::DIST_W'(cfg.range);

   always_ff @(posedge clock) begin
      sqx_ff <= sqx_in;
      sqy_ff <= sqy_in;
      rsq_ff <= rsq_in;
   end

   // Classify the word.
   assign dist_sq = (rhc_pkg::DIST_W'(sqx_ff) + rhc_pkg::DIST_W'(sqy_ff))
                    << rhc_pkg::POS_SQ_SHIFT;
   assign near    = dist_sq < rsq_ff;
   assign in_grid = rhc_pkg::CELLS_W'(index_ff) < rhc_pkg::CELLS_W'(rhc_pkg::GRID_CELLS);

   always_comb begin
      if (op_ff == rhc_pkg::OP_CLEAR) begin
         push_data.kind = rhc_pkg::KIND_CLEAR;
      end else if (!cfg.enabled) begin
         push_data.kind = rhc_pkg::KIND_OFF;
      end else begin
         push_data.kind = rhc_pkg::KIND_CELL;
      end
      push_data.index    = index_ff;
      push_data.prob     = (prob_ff > rhc_pkg::PROB_W'(rhc_pkg::Q_ONE)) ?
                           rhc_pkg::PROB_W'(rhc_pkg::Q_ONE) : prob_ff;
      push_data.in_grid  = in_grid;
      push_data.eligible = in_grid && visible_ff && (cfg.shadow || !near);
      push_data.last     = last_ff;
   end

endmodule

### sv/rhc_queue.sv
module rhc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  rhc_pkg::work_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output rhc_pkg::work_type out_data
);

   rhc_pkg::work_type             slots_ff [rhc_pkg::QUEUE_DEPTH];
   logic [rhc_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [rhc_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [rhc_pkg::QFILL_W-1:0]   fill_ff, fill_in;
   logic                          push, pop;

   assign in_ready  = fill_ff != rhc_pkg::QFILL_W'(rhc_pkg::QUEUE_DEPTH);
   assign out_valid = fill_ff != '0;
   assign out_data  = slots_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == rhc_pkg::QPTR_W'(rhc_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == rhc_pkg::QPTR_W'(rhc_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Slot storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

### sv/rhc_back.sv
`include "risk_grid_hysteresis_cost_defines.svh"

module rhc_back (
   input  logic                        clock,
   input  logic                        reset,
   input  rhc_pkg::cfg_type            cfg,
   output logic                        init_busy,
   input  logic                        q_valid,
   output logic                        q_ready,
   input  rhc_pkg::work_type           q_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [rhc_pkg::INDEX_W-1:0] rsp_out_index,
   output logic [rhc_pkg::COST_W-1:0]  rsp_cell_cost,
   output logic                        rsp_cell_active,
   output logic                        rsp_frame_done,
   output logic [rhc_pkg::TOTAL_W-1:0] rsp_active_total,
   output logic [rhc_pkg::COST_W-1:0]  rsp_peak_cost
);

   rhc_pkg::back_state_type state_ff, state_in;
   rhc_pkg::work_type       work_ff, work_in;

   // Active mark memory, one bit per cell.
   logic                        marks [rhc_pkg::GRID_CELLS];
   logic                        rd_ff;
   logic                        mark_we;
   logic [rhc_pkg::ADDR_W-1:0]  mark_addr;
   logic                        mark_wd;

   logic [rhc_pkg::ADDR_W-1:0]  wipe_ff, wipe_in;
   logic                        dirty_ff, dirty_in;

   logic [rhc_pkg::LEVEL_W-1:0] thr_ff, thr_in;
   logic                        hit_ff, hit_in;
   logic [rhc_pkg::PROB_W-1:0]  diff_ff, diff_in;
   logic [rhc_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic [rhc_pkg::NUM_W-1:0]   num_ff, num_in;
   logic [rhc_pkg::NUM_W-1:0]   den_ff, den_in;
   logic [rhc_pkg::QUOT_W-1:0]  quot_ff, quot_in;
   logic [rhc_pkg::STEP_W-1:0]  step_ff, step_in;

   logic [rhc_pkg::TOTAL_W-1:0] count_ff, count_in;
   logic [rhc_pkg::COST_W-1:0]  peak_ff, peak_in;

   logic                        out_valid_ff, out_valid_in;
   logic [rhc_pkg::INDEX_W-1:0] out_index_ff, out_index_in;
   logic [rhc_pkg::COST_W-1:0]  out_cost_ff, out_cost_in;
   logic                        out_active_ff, out_active_in;
   logic                        out_done_ff, out_done_in;
   logic [rhc_pkg::TOTAL_W-1:0] out_total_ff, out_total_in;
   logic [rhc_pkg::COST_W-1:0]  out_peak_ff, out_peak_in;

   logic                        mark_now;
   logic [rhc_pkg::LEVEL_W-1:0] thr_sel;
   logic [rhc_pkg::PROB_W-1:0]  span;
   logic                        ge;
   logic [rhc_pkg::COST_W-1:0]  cost_raw;
   logic [rhc_pkg::COST_W-1:0]  cost;
   logic [rhc_pkg::TOTAL_W-1:0] count_next;
   logic [rhc_pkg::COST_W-1:0]  peak_next;
   logic                        slot_free;

   assign init_busy = state_ff == rhc_pkg::B_INIT;
   assign slot_free = !out_valid_ff || rsp_ready;

   // Datapath terms shared by the states.
   assign mark_now = work_ff.in_grid && rd_ff;
   assign thr_sel  = mark_now ? cfg.rel_level : cfg.act_level;
   assign span     = rhc_pkg::PROB_W'(rhc_pkg::Q_ONE) - rhc_pkg::PROB_W'(thr_ff);
   assign ge       = num_ff >= den_ff;
   assign cost_raw = quot_ff + 1'b1;
   assign cost     = !hit_ff ? '0 : ((cost_raw > cfg.ceiling) ? cfg.ceiling : cost_raw);

   // Frame summary after this cell.
   always_comb begin
      count_next = count_ff;
      peak_next  = peak_ff;
      if (hit_ff) begin
         if (count_ff < rhc_pkg::TOTAL_W'(rhc_pkg::COUNT_MAX)) begin
            count_next = count_ff + 1'b1;
         end
         if (cost > peak_ff) begin
            peak_next = cost;
         end
      end
   end

   // Back sequencer: mark memory sweep, mark lookup, threshold, multiply, divider, result.
   always_comb begin
      state_in      = state_ff;
      work_in       = work_ff;
      q_ready       = 1'b0;
      mark_we       = 1'b0;
      mark_addr     = work_ff.index[rhc_pkg::ADDR_W-1:0];
      mark_wd       = 1'b0;
      wipe_in       = wipe_ff;
      dirty_in      = dirty_ff;
      thr_in        = thr_ff;
      hit_in        = hit_ff;
      diff_in       = diff_ff;
      prod_in       = prod_ff;
      num_in        = num_ff;
      den_in        = den_ff;
      quot_in       = quot_ff;
      step_in       = step_ff;
      count_in      = count_ff;
      peak_in       = peak_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_index_in  = out_index_ff;
      out_cost_in   = out_cost_ff;
      out_active_in = out_active_ff;
      out_done_in   = out_done_ff;
      out_total_in  = out_total_ff;
      out_peak_in   = out_peak_ff;
      unique case (state_ff)
         rhc_pkg::B_INIT, rhc_pkg::B_WIPE: begin
            mark_we   = 1'b1;
            mark_addr = wipe_ff;
            mark_wd   = 1'b0;
            wipe_in   = wipe_ff + 1'b1;
            if (wipe_ff == rhc_pkg::ADDR_W'(rhc_pkg::GRID_CELLS - 1)) begin
               wipe_in  = '0;
               dirty_in = 1'b0;
               state_in = rhc_pkg::B_IDLE;
            end
         end
         rhc_pkg::B_IDLE: begin
            q_ready = 1'b1;
            if (q_valid) begin
               work_in = q_data;
               hit_in  = 1'b0;
               if (q_data.kind == rhc_pkg::KIND_CELL) begin
                  state_in = rhc_pkg::B_READ;
               end else begin
                  state_in = rhc_pkg::B_FIN;
               end
            end
         end
         rhc_pkg::B_READ: begin
            state_in = rhc_pkg::B_LEVEL;
         end
         rhc_pkg::B_LEVEL: begin
            thr_in  = thr_sel;
            hit_in  = work_ff.eligible && (work_ff.prob >= rhc_pkg::PROB_W'(thr_sel));
            diff_in = work_ff.prob - rhc_pkg::PROB_W'(thr_sel);
            if (work_ff.eligible && (work_ff.prob >= rhc_pkg::PROB_W'(thr_sel))) begin
               state_in = rhc_pkg::B_MUL;
            end else begin
               state_in = rhc_pkg::B_FIN;
            end
         end
         rhc_pkg::B_MUL: begin
            prod_in  = rhc_pkg::PROD_W'(diff_ff) *
                       rhc_pkg::PROD_W'(cfg.ceiling - 1'b1);
            state_in = rhc_pkg::B_PREP;
         end
         rhc_pkg::B_PREP: begin
            // Round half up: quotient of (2a + b) by 2b.
            num_in   = {prod_ff, 1'b0} + rhc_pkg::NUM_W'(span);
            den_in   = rhc_pkg::NUM_W'({span, 1'b0}) << (rhc_pkg::QUOT_W - 1);
            quot_in  = '0;
            step_in  = rhc_pkg::STEP_W'(rhc_pkg::QUOT_W - 1);
            state_in = rhc_pkg::B_DIV;
         end
         rhc_pkg::B_DIV: begin
            // One restoring step per cycle, most significant bit first.
            if (ge) begin
               num_in = num_ff - den_ff;
            end
            quot_in = {quot_ff[rhc_pkg::QUOT_W-2:0], ge};
            den_in  = den_ff >> 1;
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = rhc_pkg::B_FIN;
            end
         end
         rhc_pkg::B_FIN: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_index_in = work_ff.index;
               out_total_in = '0;
               out_peak_in  = '0;
               if (work_ff.kind == rhc_pkg::KIND_CELL) begin
                  out_cost_in   = cost;
                  out_active_in = hit_ff;
                  out_done_in   = work_ff.last;
                  mark_we       = work_ff.in_grid;
                  mark_wd       = hit_ff;
                  if (hit_ff) begin
                     dirty_in = 1'b1;
                  end
                  if (work_ff.last) begin
                     out_total_in = count_next;
                     out_peak_in  = peak_next;
                     count_in     = '0;
                     peak_in      = '0;
                  end else begin
                     count_in = count_next;
                     peak_in  = peak_next;
                  end
                  state_in = rhc_pkg::B_IDLE;
               end else begin
                  // Clear or disabled: every mark and the frame summary go to zero.
                  out_cost_in   = '0;
                  out_active_in = 1'b0;
                  out_done_in   = (work_ff.kind == rhc_pkg::KIND_OFF) && work_ff.last;
                  count_in      = '0;
                  peak_in       = '0;
                  state_in      = dirty_ff ? rhc_pkg::B_WIPE : rhc_pkg::B_IDLE;
               end
            end
         end
         default: begin
            state_in = rhc_pkg::B_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rhc_pkg::B_INIT;
         wipe_ff      <= '0;
         dirty_ff     <= 1'b0;
         count_ff     <= '0;
         peak_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wipe_ff      <= wipe_in;
         dirty_ff     <= dirty_in;
         count_ff     <= count_in;
         peak_ff      <= peak_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Working and result payload registers.
   always_ff @(posedge clock) begin
      work_ff       <= work_in;
      thr_ff        <= thr_in;
      hit_ff        <= hit_in;
      diff_ff       <= diff_in;
      prod_ff       <= prod_in;
      num_ff        <= num_in;
      den_ff        <= den_in;
      quot_ff       <= quot_in;
      step_ff       <= step_in;
      out_index_ff  <= out_index_in;
      out_cost_ff   <= out_cost_in;
      out_active_ff <= out_active_in;
      out_done_ff   <= out_done_in;
      out_total_ff  <= out_total_in;
      out_peak_ff   <= out_peak_in;
   end

   // Mark memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mark_we) begin
         marks[mark_addr] <= mark_wd;
      end
      rd_ff <= marks[work_ff.index[rhc_pkg::ADDR_W-1:0]];
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_out_index    = out_index_ff;
   assign rsp_cell_cost    = out_cost_ff;
   assign rsp_cell_active  = out_active_ff;
   assign rsp_frame_done   = out_done_ff;
   assign rsp_active_total = out_total_ff;
   assign rsp_peak_cost    = out_peak_ff;

   // The rounded quotient never reaches the ceiling, so the clamp only guards.
   `RHC_ASSERT_IMP(a_quot_below_ceiling, clock, reset,
      (state_ff == rhc_pkg::B_FIN) && (work_ff.kind == rhc_pkg::KIND_CELL) && hit_ff,
      quot_ff < cfg.ceiling)
   // A word shown as active carries a cost, an inactive one carries none.
   `RHC_ASSERT_IMP(a_cost_matches_active, clock, reset,
      out_valid_ff, out_active_ff == (out_cost_ff != '0))
   // Summary fields are zero off the frame end.
   `RHC_ASSERT_IMP(a_summary_off_frame, clock, reset,
      out_valid_ff && !out_done_ff, (out_total_ff == '0) && (peak_ff <= peak_ff) &&
      (out_peak_ff == '0))
   // A finished sweep leaves the memory clean.
   `RHC_ASSERT_NXT(a_wipe_cleans, clock, reset,
      (state_ff == rhc_pkg::B_WIPE) &&
      (wipe_ff == rhc_pkg::ADDR_W'(rhc_pkg::GRID_CELLS - 1)),
      !dirty_ff && (state_ff == rhc_pkg::B_IDLE))

endmodule

### sv/risk_grid_hysteresis_cost.sv
// From acceptance to rsp_valid a word passes the front, the work queue and the back end;
// a cell that turns active adds B_MUL, B_PREP and a 7-step serial divider for the cost,
// a clear or disabled word skips the mark lookup. The back end takes one word at a time;
// a clear or disabled word finding marks set since the last sweep adds a mark memory sweep.
// Reset (synchronous, active high) loads the register defaults and starts a sweep that
// zeroes the mark memory; req_ready stays low during it, csr writes are taken.
module risk_grid_hysteresis_cost (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_op,
   input  logic [rhc_pkg::INDEX_W-1:0]    req_cell_index,
   input  logic [rhc_pkg::PROB_W-1:0]     req_probability,
   input  logic                           req_visible,
   input  logic                           req_frame_last,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [rhc_pkg::INDEX_W-1:0]    rsp_out_index,
   output logic [rhc_pkg::COST_W-1:0]     rsp_cell_cost,
   output logic                           rsp_cell_active,
   output logic                           rsp_frame_done,
   output logic [rhc_pkg::TOTAL_W-1:0]    rsp_active_total,
   output logic [rhc_pkg::COST_W-1:0]     rsp_peak_cost,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [rhc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rhc_pkg::CSR_DATA_W-1:0] csr_data
);

   logic                        enabled_ff;
   logic                        shadow_ff;
   logic [rhc_pkg::LEVEL_W-1:0] act_ff;
   logic [rhc_pkg::LEVEL_W-1:0] rel_ff;
   logic [rhc_pkg::COST_W-1:0]  ceiling_ff;
   logic [rhc_pkg::RANGE_W-1:0] range_ff;

   rhc_pkg::cfg_type  cfg;
   logic [rhc_pkg::LEVEL_W-1:0] act_used;
   logic              init_busy;
   logic              push_valid, push_ready;
   rhc_pkg::work_type push_data;
   logic              q_valid, q_ready;
   rhc_pkg::work_type q_data;

   assign csr_ready = 1'b1;

   // Configuration registers, held as written.
   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b1;
         shadow_ff  <= 1'b1;
         act_ff     <= rhc_pkg::LEVEL_W'(32768);
         rel_ff     <= rhc_pkg::LEVEL_W'(19661);
         ceiling_ff <= rhc_pkg::COST_W'(rhc_pkg::COST_MAX);
         range_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (rhc_pkg::csr_index_type'(csr_index))
            rhc_pkg::CSR_ENABLE:   enabled_ff <= csr_data[0];
            rhc_pkg::CSR_SHADOW:   shadow_ff  <= csr_data[0];
            rhc_pkg::CSR_ACTIVATE: act_ff     <= csr_data[rhc_pkg::LEVEL_W-1:0];
            rhc_pkg::CSR_RELEASE:  rel_ff     <= csr_data[rhc_pkg::LEVEL_W-1:0];
            rhc_pkg::CSR_CEILING:  ceiling_ff <= csr_data[rhc_pkg::COST_W-1:0];
            rhc_pkg::CSR_RANGE:    range_ff   <= csr_data[rhc_pkg::RANGE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Clamp the registers to the ranges the datapath uses.
   always_comb begin
      if (act_ff < rhc_pkg::LEVEL_W'(rhc_pkg::ACT_MIN)) begin
         act_used = rhc_pkg::LEVEL_W'(rhc_pkg::ACT_MIN);
      end else if (act_ff > rhc_pkg::LEVEL_W'(rhc_pkg::ACT_MAX)) begin
         act_used = rhc_pkg::LEVEL_W'(rhc_pkg::ACT_MAX);
      end else begin
         act_used = act_ff;
      end
      cfg.enabled   = enabled_ff;
      cfg.shadow    = shadow_ff;
      cfg.act_level = act_used;
      cfg.rel_level = (rel_ff > act_used) ? act_used : rel_ff;
      if (ceiling_ff == '0) begin
         cfg.ceiling = rhc_pkg::COST_W'(1);
      end else if (ceiling_ff > rhc_pkg::COST_W'(rhc_pkg::COST_MAX)) begin
         cfg.ceiling = rhc_pkg::COST_W'(rhc_pkg::COST_MAX);
      end else begin
         cfg.ceiling = ceiling_ff;
      end
      cfg.range = (range_ff > rhc_pkg::RANGE_W'(rhc_pkg::RANGE_MAX)) ?
                  rhc_pkg::RANGE_W'(rhc_pkg::RANGE_MAX) : range_ff;
   end

   rhc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .init_busy      (init_busy),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_cell_index (req_cell_index),
      .req_probability(req_probability),
      .req_visible    (req_visible),
      .req_frame_last (req_frame_last),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_data      (push_data)
   );

   rhc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .in_valid (push_valid),
      .in_ready (push_ready),
      .in_data  (push_data),
      .out_valid(q_valid),
      .out_ready(q_ready),
      .out_data (q_data)
   );

   rhc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .init_busy       (init_busy),
      .q_valid         (q_valid),
      .q_ready         (q_ready),
      .q_data          (q_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_index   (rsp_out_index),
      .rsp_cell_cost   (rsp_cell_cost),
      .rsp_cell_active (rsp_cell_active),
      .rsp_frame_done  (rsp_frame_done),
      .rsp_active_total(rsp_active_total),
      .rsp_peak_cost   (rsp_peak_cost)
   );

endmodule
